@@ rtl/tpp_pkg.sv @@
// Shared types and constants of the trapezoidal path profile core.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package tpp_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int DIV_STEPS   = 51;
    localparam int SQRT_STEPS  = 26;

    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [30:0] MAX31   = 31'h7FFF_FFFF;
    localparam logic [30:0] CFG_RST = 31'h0001_0000;

    typedef enum logic {
        REG_MAX_VELOCITY = 1'b0,
        REG_ACCEL_RATE   = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        SEG_REST,
        SEG_UP,
        SEG_CRUISE,
        SEG_DOWN,
        SEG_DONE
    } seg_t;

    typedef enum logic [2:0] {
        SU_SQ,
        SU_TEST,
        SU_DIV,
        SU_SQRT,
        SU_HP_SQ,
        SU_HP_MUL,
        SU_HP_FIN,
        SU_DONE
    } setup_state_t;

    typedef struct packed {
        logic [48:0] end_pt;
        logic [47:0] plateau;
        logic [32:0] rampdown;
        logic [30:0] end_sat;
        logic [16:0] hp_clip;
    } bp_t;

    typedef struct packed {
        seg_t        seg;
        logic [47:0] opnd;
    } item_t;

endpackage

@@ rtl/tpp_setup.sv @@
// Breakpoint sequencer: shared restoring divider, digit square root and multiplier.
// Depends on tpp_pkg.
`timescale 1ns / 1ps

module tpp_setup import tpp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [30:0] vel_max,
    input  logic [30:0] accel,
    output bp_t         bp,
    output logic        ready
);

    setup_state_t state_reg, state_next;

    logic        tri_reg;
    logic        pass_reg;
    logic [5:0]  cnt_reg;
    logic [50:0] quo_reg;
    logic [30:0] rem_reg;
    logic [51:0] rad_reg;
    logic [25:0] root_reg;
    logic [27:0] srem_reg;
    logic [65:0] mul_p_reg;
    logic        hq_ovf_reg;
    bp_t         bp_reg;

    logic [32:0] mul_x, mul_y;
    logic [30:0] den;
    logic [31:0] rsh;
    logic        dge;
    logic [50:0] quo_nx;
    logic [29:0] srem_sh, trial;
    logic        sge;
    logic [25:0] root_nx;
    logic [48:0] end_sum;
    logic [46:0] hval;
    logic        div_last, sqrt_last;

    assign den      = pass_reg ? vel_max : accel;
    assign rsh      = {rem_reg, quo_reg[50]};
    assign dge      = rsh >= {1'b0, den};
    assign quo_nx   = {quo_reg[49:0], dge};
    assign srem_sh  = {srem_reg, rad_reg[51:50]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign sge      = srem_sh >= trial;
    assign root_nx  = {root_reg[24:0], sge};
    assign end_sum  = {1'b0, bp_reg.plateau} + {16'b0, quo_nx[32:0]};
    assign hval     = mul_p_reg[63:17];
    assign div_last  = cnt_reg == 6'(DIV_STEPS - 1);
    assign sqrt_last = cnt_reg == 6'(SQRT_STEPS - 1);

    assign bp    = bp_reg;
    assign ready = (state_reg == SU_DONE) && !start;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SU_SQ;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mul_x      = '0;
        mul_y      = '0;
        unique case (state_reg)
            SU_SQ: begin
                mul_x      = {2'b00, vel_max};
                mul_y      = {2'b00, vel_max};
                state_next = SU_TEST;
            end
            SU_TEST: state_next = SU_DIV;
            SU_DIV: begin
                if (div_last) begin
                    if (tri_reg) begin
                        state_next = SU_SQRT;
                    end else if (pass_reg) begin
                        state_next = SU_HP_SQ;
                    end
                end
            end
            SU_SQRT: begin
                if (sqrt_last) begin
                    state_next = SU_HP_SQ;
                end
            end
            SU_HP_SQ: begin
                mul_x = {8'b0, bp_reg.plateau[24:0]};
                mul_y = {8'b0, bp_reg.plateau[24:0]};
                state_next = (|bp_reg.plateau[47:25]) ? SU_DONE : SU_HP_MUL;
            end
            SU_HP_MUL: begin
                mul_x      = {2'b00, accel};
                mul_y      = mul_p_reg[48:16];
                state_next = SU_HP_FIN;
            end
            SU_HP_FIN: state_next = SU_DONE;
            SU_DONE:   state_next = SU_DONE;
            default:   state_next = SU_SQ;
        endcase
        if (start) begin
            state_next = SU_SQ;
        end
    end

    always_ff @(posedge aclk) begin
        mul_p_reg <= mul_x * mul_y;
        unique case (state_reg)
            SU_TEST: begin
                tri_reg  <= {accel, 16'b0} < mul_p_reg[61:0];
                pass_reg <= 1'b0;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= ({accel, 16'b0} < mul_p_reg[61:0]) ?
                            {1'b1, 50'b0} : {4'b0, vel_max, 16'b0};
            end
            SU_DIV: begin
                if (div_last) begin
                    cnt_reg <= '0;
                    if (tri_reg) begin
                        rad_reg  <= {1'b0, quo_nx};
                        root_reg <= '0;
                        srem_reg <= '0;
                    end else if (!pass_reg) begin
                        bp_reg.plateau <= quo_nx[47:0];
                        quo_reg  <= 51'h1_0000_0000;
                        rem_reg  <= '0;
                        pass_reg <= 1'b1;
                    end else begin
                        bp_reg.rampdown <= quo_nx[32:0];
                        bp_reg.end_pt   <= end_sum;
                        bp_reg.end_sat  <= (|end_sum[48:31]) ? MAX31 : end_sum[30:0];
                    end
                end else begin
                    rem_reg <= dge ? 31'(rsh - {1'b0, den}) : rsh[30:0];
                    quo_reg <= quo_nx;
                    cnt_reg <= cnt_reg + 6'd1;
                end
            end
            SU_SQRT: begin
                srem_reg <= sge ? 28'(srem_sh - trial) : srem_sh[27:0];
                root_reg <= root_nx;
                rad_reg  <= {rad_reg[49:0], 2'b00};
                cnt_reg  <= cnt_reg + 6'd1;
                if (sqrt_last) begin
                    bp_reg.end_pt   <= {23'b0, root_nx};
                    bp_reg.plateau  <= {23'b0, root_nx[25:1]};
                    bp_reg.rampdown <= {8'b0, root_nx[25:1]};
                    bp_reg.end_sat  <= {5'b0, root_nx};
                end
            end
            SU_HP_SQ: begin
                if (|bp_reg.plateau[47:25]) begin
                    bp_reg.hp_clip <= ONE_Q16;
                end
            end
            SU_HP_MUL: hq_ovf_reg <= mul_p_reg[49];
            SU_HP_FIN: begin
                bp_reg.hp_clip <= (hq_ovf_reg || (|hval[46:16])) ? ONE_Q16 : hval[16:0];
            end
            default: ;
        endcase
    end

endmodule

@@ rtl/tpp_front.sv @@
// Front end: accepts time samples, classifies the profile segment, forms the operand.
// Depends on tpp_pkg.
`timescale 1ns / 1ps

module tpp_front import tpp_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH,
    parameter int CW     = $clog2(QDEPTH + 1)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_sample_time,
    input  bp_t                bp,
    input  logic               bp_ready,
    input  logic [CW-1:0]      q_count,
    output logic               push,
    output item_t              push_item
);

    logic               fr_valid_reg;
    item_t              fr_item_reg;
    item_t              item_next;
    logic signed [49:0] t_x, end_x, ramp_x, plat_x, d_dn, d_cr;
    logic [CW:0]        used;

    assign t_x    = {{18{s_sample_time[31]}}, s_sample_time};
    assign end_x  = {1'b0, bp.end_pt};
    assign ramp_x = {17'b0, bp.rampdown};
    assign plat_x = {2'b0, bp.plateau};
    assign d_dn   = end_x - t_x;
    assign d_cr   = t_x - plat_x;

    assign used    = {1'b0, q_count} + {{CW{1'b0}}, fr_valid_reg};
    assign s_ready = bp_ready && (used < (CW + 1)'(QDEPTH));

    always_comb begin
        item_next = '{seg: SEG_REST, opnd: '0};
        priority if (t_x > end_x) begin
            item_next.seg = SEG_DONE;
        end else if (t_x > ramp_x) begin
            item_next.seg  = SEG_DOWN;
            item_next.opnd = d_dn[47:0];
        end else if (t_x > plat_x) begin
            item_next.seg  = SEG_CRUISE;
            item_next.opnd = d_cr[47:0];
        end else if (t_x > 50'sd0) begin
            item_next.seg  = SEG_UP;
            item_next.opnd = {17'b0, s_sample_time[30:0]};
        end else begin
            item_next.seg = SEG_REST;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_valid_reg <= 1'b0;
        end else begin
            fr_valid_reg <= s_valid && s_ready;
        end
        if (s_valid && s_ready) begin
            fr_item_reg <= item_next;
        end
    end

    assign push      = fr_valid_reg;
    assign push_item = fr_item_reg;

endmodule

@@ rtl/tpp_queue.sv @@
// Small request queue between front and back end.
// Depends on tpp_pkg.
`timescale 1ns / 1ps

module tpp_queue import tpp_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH,
    parameter int CW     = $clog2(QDEPTH + 1),
    parameter int AW     = $clog2(QDEPTH)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  item_t         push_item,
    input  logic          pop,
    output item_t         head,
    output logic          empty,
    output logic [CW-1:0] count
);

    item_t         slot_reg [QDEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = count_reg == '0;
    assign count = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ rtl/tpp_back.sv @@
// Back end: three-stage multiply pipeline forming position, velocity and acceleration.
// Depends on tpp_pkg.
`timescale 1ns / 1ps

module tpp_back import tpp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  item_t              head,
    input  logic               empty,
    output logic               pop,
    input  logic [30:0]        vel_max,
    input  logic [30:0]        accel,
    input  logic [16:0]        hp_clip,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [16:0]        m_position,
    output logic [30:0]        m_velocity,
    output logic signed [31:0] m_acceleration
);

    logic        en;
    logic        b1_valid_reg, b2_valid_reg, out_valid_reg;
    seg_t        seg1_reg, seg2_reg;
    logic [49:0] sq1_reg;
    logic        sqo1_reg;
    logic [54:0] pl1_reg, ph1_reg;
    logic        qo2_reg;
    logic [63:0] hm2_reg;
    logic [30:0] vel2_reg;
    logic [16:0] lin2_reg;
    logic [16:0] pos_reg;
    logic [30:0] vel_reg;
    logic [31:0] acc_reg;

    logic [30:0] mx;
    logic [78:0] prod;
    logic [62:0] vr;
    logic [46:0] hval;
    logic [16:0] hc;
    logic [17:0] cr_sum;
    logic [16:0] pos_next;
    logic [30:0] vel_next;
    logic [31:0] acc_next;

    assign en  = !out_valid_reg || m_ready;
    assign pop = en && !empty;
    assign mx  = (head.seg == SEG_CRUISE) ? vel_max : accel;

    assign prod   = {ph1_reg, 24'b0} + {24'b0, pl1_reg};
    assign vr     = prod[78:16];
    assign hval   = hm2_reg[63:17];
    assign hc     = (qo2_reg || (|hval[46:16])) ? ONE_Q16 : hval[16:0];
    assign cr_sum = {1'b0, hp_clip} + {1'b0, lin2_reg};

    always_comb begin
        pos_next = '0;
        vel_next = '0;
        acc_next = '0;
        unique case (seg2_reg)
            SEG_DONE: pos_next = ONE_Q16;
            SEG_DOWN: begin
                pos_next = ONE_Q16 - hc;
                vel_next = vel2_reg;
                acc_next = 32'(-{1'b0, accel});
            end
            SEG_CRUISE: begin
                pos_next = (cr_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : cr_sum[16:0];
                vel_next = vel_max;
            end
            SEG_UP: begin
                pos_next = hc;
                vel_next = vel2_reg;
                acc_next = {1'b0, accel};
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            b1_valid_reg  <= !empty;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
        end
        if (en) begin
            seg1_reg <= head.seg;
            sq1_reg  <= head.opnd[24:0] * head.opnd[24:0];
            sqo1_reg <= |head.opnd[47:25];
            pl1_reg  <= mx * head.opnd[23:0];
            ph1_reg  <= mx * head.opnd[47:24];

            seg2_reg <= seg1_reg;
            qo2_reg  <= sqo1_reg || sq1_reg[49];
            hm2_reg  <= accel * sq1_reg[48:16];
            vel2_reg <= (|vr[62:31]) ? MAX31 : vr[30:0];
            lin2_reg <= (|vr[62:16]) ? ONE_Q16 : vr[16:0];

            pos_reg <= pos_next;
            vel_reg <= vel_next;
            acc_reg <= acc_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_position     = pos_reg;
    assign m_velocity     = vel_reg;
    assign m_acceleration = acc_reg;

endmodule

@@ rtl/trapezoidal_path_profile_core.sv @@
// Trapezoidal path profile core: one sample per cycle while s_ready is high.
// Throughput is one item per cycle through the three-stage multiply back end unless m_ready stalls it.
// After reset or any register write the breakpoint sequencer squares vel_max, divides,
// then takes a square root or divides again, forms hp_clip; s_ready stays low meanwhile.
// Reset is synchronous, active low; registers return to 1.0.
`timescale 1ns / 1ps

module trapezoidal_path_profile_core import tpp_pkg::*; #(
    parameter int QDEPTH = QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [30:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_sample_time,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [16:0]        m_position,
    output logic [30:0]        m_velocity,
    output logic signed [31:0] m_acceleration,
    output logic [30:0]        m_end_time
);

    localparam int CW = $clog2(QDEPTH + 1);

    logic [30:0]   vmax_reg, accel_reg;
    logic [30:0]   v_eff, a_eff;
    bp_t           bp;
    logic          bp_ready;
    logic [CW-1:0] q_count;
    logic          push, pop, q_empty;
    item_t         push_item, head;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vmax_reg  <= CFG_RST;
            accel_reg <= CFG_RST;
        end else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_index))
                REG_MAX_VELOCITY: vmax_reg  <= cfg_data;
                REG_ACCEL_RATE:   accel_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign v_eff = (vmax_reg == '0) ? 31'd1 : vmax_reg;
    assign a_eff = (accel_reg == '0) ? 31'd1 : accel_reg;

    tpp_setup u_setup (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cfg_we),
        .vel_max (v_eff),
        .accel   (a_eff),
        .bp      (bp),
        .ready   (bp_ready)
    );

    tpp_front #(.QDEPTH(QDEPTH)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_time (s_sample_time),
        .bp            (bp),
        .bp_ready      (bp_ready),
        .q_count       (q_count),
        .push          (push),
        .push_item     (push_item)
    );

    tpp_queue #(.QDEPTH(QDEPTH)) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .count     (q_count)
    );

    tpp_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head           (head),
        .empty          (q_empty),
        .pop            (pop),
        .vel_max        (v_eff),
        .accel          (a_eff),
        .hp_clip        (bp.hp_clip),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_position     (m_position),
        .m_velocity     (m_velocity),
        .m_acceleration (m_acceleration)
    );

    assign m_end_time = bp.end_sat;

endmodule
